FILE: hdl/dsb_pkg.sv
package dsb_pkg;

    localparam int STEPS       = 20;
    localparam int LOW_W       = 20;
    localparam int DELTA_W     = 16;
    localparam int COEF_W      = 22;
    localparam int WORD_W      = 64;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 104;

    // f and g are packed with their matrix coefficients
    localparam logic [WORD_W-1:0] F_PACK_OFFSET = 64'h0000_0200_0000_0000;
    localparam logic [WORD_W-1:0] G_PACK_OFFSET = 64'h4000_0000_0000_0000;
    localparam logic [WORD_W-1:0] ROUND_HI      = 64'h0000_0200_0010_0000;
    localparam logic [WORD_W-1:0] ROUND_LO      = 64'h0000_0000_0010_0000;

    typedef struct packed {
        logic [WORD_W-1:0]  fw;
        logic [WORD_W-1:0]  gw;
        logic [DELTA_W-1:0] delta;
    } dsb_state_t;

    typedef struct packed {
        logic [COEF_W-1:0]  s_coef;
        logic [COEF_W-1:0]  r_coef;
        logic [COEF_W-1:0]  v_coef;
        logic [COEF_W-1:0]  u_coef;
        logic [DELTA_W-1:0] delta_out;
    } dsb_result_t;

endpackage

FILE: hdl/dsb_cell.sv
module dsb_cell import dsb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dsb_state_t in_state,
    output logic       out_valid,
    input  logic       out_ready,
    output dsb_state_t out_state
);

    logic       valid_reg;
    logic       valid_next;
    dsb_state_t state_reg;
    dsb_state_t state_next;

    logic              odd;
    logic              nonpos;
    logic              swap;
    logic [WORD_W-1:0] addend;
    logic [WORD_W-1:0] sum;

    assign odd    = in_state.gw[0];
    assign nonpos = (in_state.delta == '0) || in_state.delta[DELTA_W-1];
    assign swap   = odd && nonpos;

    // one adder serves both branches: subtract f on a swap, add f when g is odd
    always_comb begin
        if (swap) begin
            addend = ~in_state.fw + {{(WORD_W-1){1'b0}}, 1'b1};
        end else if (odd) begin
            addend = in_state.fw;
        end else begin
            addend = '0;
        end
        sum = in_state.gw + addend;

        state_next.gw = {sum[WORD_W-1], sum[WORD_W-1:1]};
        if (swap) begin
            state_next.fw    = in_state.gw;
            state_next.delta = '0 - in_state.delta;
        end else begin
            state_next.fw    = in_state.fw;
            state_next.delta = in_state.delta - {{(DELTA_W-1){1'b0}}, 1'b1};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

FILE: hdl/dsb_extract.sv
module dsb_extract import dsb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  dsb_state_t  in_state,
    output logic        out_valid,
    input  logic        out_ready,
    output dsb_result_t out_result
);

    logic        valid_reg;
    logic        valid_next;
    dsb_result_t result_reg;
    dsb_result_t result_next;

    logic [WORD_W-1:0] f_hi;
    logic [WORD_W-1:0] f_lo;
    logic [WORD_W-1:0] g_hi;
    logic [WORD_W-1:0] g_lo;

    // high coefficient sits in bits 63:42, low one in bits 41:21 after rounding
    always_comb begin
        f_hi = in_state.fw + ROUND_HI;
        f_lo = in_state.fw + ROUND_LO;
        g_hi = in_state.gw + ROUND_HI;
        g_lo = in_state.gw + ROUND_LO;
        result_next.delta_out = in_state.delta;
        result_next.v_coef    = f_hi[63:42];
        result_next.u_coef    = {f_lo[41], f_lo[41:21]};
        result_next.s_coef    = g_hi[63:42];
        result_next.r_coef    = {g_lo[41], g_lo[41:21]};
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: hdl/divstep_batch_transition_matrix.sv
// Batch of 20 safegcd divsteps on the low 20 bits of f and g, returning the new delta and
// the four transition-matrix entries scaled by 2^20. Each beat passes through a chain of 20
// divstep cells and one extraction stage, and one beat per cycle is accepted and delivered
// when the result side keeps up. Every cell holds one beat and moves on as soon as the next
// cell has room, so gaps close up and input is still taken while a finished result waits at
// the output, until every cell is full.
module divstep_batch_transition_matrix import dsb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // f_low[19:0], g_low[39:20], delta_in[55:40]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // delta_out, u_coef, v_coef, r_coef, s_coef
);

    dsb_state_t  init_state;
    dsb_state_t  chain_state [STEPS+1];
    logic        chain_valid [STEPS+1];
    logic        chain_ready [STEPS+1];
    dsb_result_t result;

    always_comb begin
        init_state.fw    = {{(WORD_W-LOW_W){1'b0}}, s_tdata[LOW_W-1:0]} - F_PACK_OFFSET;
        init_state.gw    = {{(WORD_W-LOW_W){1'b0}}, s_tdata[2*LOW_W-1:LOW_W]} - G_PACK_OFFSET;
        init_state.delta = s_tdata[2*LOW_W+DELTA_W-1:2*LOW_W];
    end

    assign chain_state[0] = init_state;
    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        dsb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_state  (chain_state[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_state (chain_state[i+1])
        );
    end

    dsb_extract u_extract (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[STEPS]),
        .in_ready   (chain_ready[STEPS]),
        .in_state   (chain_state[STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = result;

    // a free result side lets every cell advance, so input is never held off
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is free");

    a_first_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> chain_valid[1])
        else $error("accepted beat missing from first cell");

    a_no_early_result: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid straight after reset");

    a_last_cell_hands_on: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid[STEPS] && chain_ready[STEPS] |=> m_tvalid)
        else $error("beat from last cell lost before output");

endmodule
